// ===== src/boxcar_gamma_response_eval_defines.svh =====
// Assertion macros used by the evaluator's top-level RTL file.
`ifndef BOXCAR_GAMMA_RESPONSE_EVAL_DEFINES_SVH
`define BOXCAR_GAMMA_RESPONSE_EVAL_DEFINES_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define BGRE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bgre implication check failed");

// Next-cycle implication, checked on aclk outside of reset.
`define BGRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bgre next-cycle check failed");

`endif

// ===== src/bgre_pkg.sv =====
// Shared constants, types and elaboration-time tables for the response evaluator.
`default_nettype none
package bgre_pkg;

    localparam int unsigned LaneLat = 6;
    localparam int unsigned IntCap  = 24;
    localparam logic [30:0] One30   = 31'h4000_0000;
    localparam logic [30:0] HalfSec = 31'h0000_8000;

    localparam logic [2:0] CfgStimDuration = 3'd0;
    localparam logic [2:0] CfgOnsetDelay   = 3'd1;
    localparam logic [2:0] CfgInvTimeConst = 3'd2;
    localparam logic [2:0] CfgAmplitude    = 3'd3;
    localparam logic [2:0] CfgBaseline     = 3'd4;
    localparam logic [2:0] CfgImpulseEn    = 3'd5;

    typedef struct packed {
        logic last;
        logic imp;
        logic pos;
    } side_t;

    typedef logic [30:0] ptab_t [IntCap];

    // Seventeen-term alternating series of exp(-y), y in Q1.30, truncated terms.
    function automatic logic [30:0] exp_series(input logic [30:0] y30);
        logic [63:0] term;
        logic [63:0] y;
        logic signed [64:0] sum;
        y    = 64'(y30);
        term = 64'(One30);
        sum  = 65'(One30);
        term = ((term * y) >> 30) / 64'd1;  sum = sum - 65'(term);
        term = ((term * y) >> 30) / 64'd2;  sum = sum + 65'(term);
        term = ((term * y) >> 30) / 64'd3;  sum = sum - 65'(term);
        term = ((term * y) >> 30) / 64'd4;  sum = sum + 65'(term);
        term = ((term * y) >> 30) / 64'd5;  sum = sum - 65'(term);
        term = ((term * y) >> 30) / 64'd6;  sum = sum + 65'(term);
        term = ((term * y) >> 30) / 64'd7;  sum = sum - 65'(term);
        term = ((term * y) >> 30) / 64'd8;  sum = sum + 65'(term);
        term = ((term * y) >> 30) / 64'd9;  sum = sum - 65'(term);
        term = ((term * y) >> 30) / 64'd10; sum = sum + 65'(term);
        term = ((term * y) >> 30) / 64'd11; sum = sum - 65'(term);
        term = ((term * y) >> 30) / 64'd12; sum = sum + 65'(term);
        term = ((term * y) >> 30) / 64'd13; sum = sum - 65'(term);
        term = ((term * y) >> 30) / 64'd14; sum = sum + 65'(term);
        term = ((term * y) >> 30) / 64'd15; sum = sum - 65'(term);
        term = ((term * y) >> 30) / 64'd16; sum = sum + 65'(term);
        if (sum < 0) begin
            sum = '0;
        end
        return sum[30:0];
    endfunction

    // Integer powers of exp(-1), each step rounded half up.
    function automatic ptab_t build_ptab();
        ptab_t       tab;
        logic [63:0] e1;
        logic [63:0] p;
        e1 = 64'(exp_series(One30));
        p  = 64'(One30);
        for (int i = 0; i < IntCap; i++) begin
            tab[i] = p[30:0];
            p = (p * e1 + 64'(One30 >> 1)) >> 30;
        end
        return tab;
    endfunction

    localparam ptab_t PTab = build_ptab();

endpackage
`default_nettype wire

// ===== src/bgre_lane.sv =====
// One exponential lane: scales a magnitude by 1/tau and forms poly(v)*exp(-v).
`default_nettype none
module bgre_lane #(
    parameter int unsigned ADDR_BITS = 10
) (
    input  logic        aclk,
    input  logic        adv,
    input  logic [31:0] mag,
    input  logic [31:0] inv,
    input  logic        imp,
    output logic [27:0] g
);
    import bgre_pkg::*;

    localparam int unsigned RB    = 16 - ADDR_BITS;
    localparam int unsigned Depth = 1 << ADDR_BITS;
    localparam int unsigned FrW   = 31 + RB;

    typedef logic [30:0] rom_t [Depth];

    function automatic rom_t build_rom();
        rom_t tab;
        for (int i = 0; i < Depth; i++) begin
            tab[i] = exp_series(31'(i << (30 - ADDR_BITS)));
        end
        return tab;
    endfunction

    localparam rom_t FracRom = build_rom();

    logic [47:0]    a1_reg, l1_reg;
    logic           imp1_reg;
    logic [20:0]    v2_reg;
    logic           big2_reg, imp2_reg;
    logic [30:0]    f3_reg, p3_reg;
    logic [25:0]    vv3_reg;
    logic [RB-1:0]  r3_reg;
    logic [20:0]    v3_reg;
    logic           big3_reg, imp3_reg;
    logic [FrW-1:0] fr4_reg;
    logic [30:0]    f4_reg, p4_reg;
    logic [26:0]    sel4_reg;
    logic           big4_reg;
    logic [30:0]    e5_reg;
    logic [26:0]    sel5_reg;
    logic [27:0]    g_reg;

    logic [64:0] sum2;
    logic [40:0] v2_next;
    logic        big2_next;
    logic [41:0] vv3_next;
    logic [26:0] poly4_next;
    logic [30:0] fp5_next;
    logic [61:0] pe5_next;
    logic [57:0] ge6_next;

    always_comb begin
        sum2       = {1'b0, a1_reg, 16'b0} + 65'(l1_reg);
        v2_next    = sum2[64:24];
        big2_next  = (v2_next[40:21] != '0) || (v2_next[20:16] >= 5'(IntCap));
        vv3_next   = 42'(v2_reg) * 42'(v2_reg);
        poly4_next = 27'(vv3_reg) + 27'({v3_reg, 1'b0}) + 27'(32'd1 << 17);
        fp5_next   = f4_reg - 31'(fr4_reg >> 16);
        pe5_next   = 62'(p4_reg) * 62'(fp5_next);
        ge6_next   = 58'(sel5_reg) * 58'(e5_reg) + 58'(32'd1 << 29);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg   <= 48'(mag[31:16]) * 48'(inv);
            l1_reg   <= 48'(mag[15:0]) * 48'(inv);
            imp1_reg <= imp;

            v2_reg   <= v2_next[20:0];
            big2_reg <= big2_next;
            imp2_reg <= imp1_reg;

            // The table is a ROM with a registered read.
            f3_reg   <= FracRom[v2_reg[15 -: ADDR_BITS]];
            p3_reg   <= big2_reg ? '0 : PTab[v2_reg[20:16]];
            vv3_reg  <= vv3_next[41:16];
            r3_reg   <= v2_reg[RB-1:0];
            v3_reg   <= v2_reg;
            big3_reg <= big2_reg;
            imp3_reg <= imp2_reg;

            fr4_reg  <= FrW'(f3_reg) * FrW'(r3_reg);
            f4_reg   <= f3_reg;
            p4_reg   <= p3_reg;
            sel4_reg <= imp3_reg ? 27'(vv3_reg) : poly4_next;
            big4_reg <= big3_reg;

            e5_reg   <= big4_reg ? '0 : pe5_next[60:30];
            sel5_reg <= sel4_reg;

            g_reg    <= ge6_next[57:30];
        end
    end

    assign g = g_reg;

endmodule
`default_nettype wire

// ===== src/boxcar_gamma_response_eval.sv =====
// Top level of the pipelined Boynton gamma response evaluator.
//
//  Group      Dir  Beat contents
//  s_axis     in   tdata: time_sample[31:0]; tlast: is_last
//  m_axis     out  tdata: response[31:0]; tuser: saturated; tlast: last_out
//  cfg        in   cfg_wr_en, cfg_index, cfg_wdata (one register per write)
//
// One beat per cycle is accepted while m_axis does not stall; each result passes
// through the two front stages, the six-stage exponential lanes and two back stages.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stall on m_axis freezes every stage at once, so nothing is lost or repeated.
`default_nettype none
`include "boxcar_gamma_response_eval_defines.svh"
module boxcar_gamma_response_eval #(
    parameter int unsigned EXP_TABLE_ADDR_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] time_sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] response
    output logic [0:0]  m_tuser,   // [0] saturated
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import bgre_pkg::*;

    localparam int unsigned NStg = LaneLat + 3;

    logic [30:0]        dur_reg;
    logic signed [31:0] delay_reg;
    logic [31:0]        inv_reg;
    logic signed [31:0] amp_reg;
    logic signed [31:0] base_reg;
    logic               imp_en_reg;

    logic [NStg-1:0]    vld_reg;
    side_t              side_reg [NStg];
    logic signed [32:0] tp_reg;
    logic [31:0]        magu_reg, magx_reg;
    logic signed [60:0] prod_reg;
    logic [27:0]        gu9_reg;

    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic               m_sat_reg, m_last_reg, out_imp_reg;

    logic               adv;
    logic signed [32:0] tp_next;
    side_t              side_next;
    logic [31:0]        tpl;
    logic [27:0]        gu, gx;
    logic signed [28:0] diff;
    logic signed [60:0] rnd;
    logic signed [45:0] sum;
    logic [31:0]        resp_next;
    logic               sat_next;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg    <= '0;
            delay_reg  <= '0;
            inv_reg    <= 32'h0100_0000;
            amp_reg    <= 32'sh0001_0000;
            base_reg   <= '0;
            imp_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CfgStimDuration: dur_reg    <= cfg_wdata[30:0];
                CfgOnsetDelay:   delay_reg  <= cfg_wdata;
                CfgInvTimeConst: inv_reg    <= cfg_wdata;
                CfgAmplitude:    amp_reg    <= cfg_wdata;
                CfgBaseline:     base_reg   <= cfg_wdata;
                CfgImpulseEn:    imp_en_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        tp_next        = 33'(signed'(s_tdata)) - 33'(delay_reg);
        side_next.last = s_tlast;
        side_next.imp  = imp_en_reg && (dur_reg < HalfSec);
        side_next.pos  = !tp_next[32] && (tp_next != '0);
        tpl            = tp_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NStg-2:0], s_tvalid};
            m_valid_reg <= vld_reg[NStg-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < NStg; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            tp_reg   <= tp_next;
            magu_reg <= tpl;
            // Tail past the end of the boxcar; zero while still inside it.
            magx_reg <= (tpl > {1'b0, dur_reg}) ? tpl - {1'b0, dur_reg} : '0;
            prod_reg <= 61'(amp_reg) * 61'(diff);
            gu9_reg  <= gu;
        end
    end

    bgre_lane #(.ADDR_BITS(EXP_TABLE_ADDR_BITS)) u_lane_u (
        .aclk (aclk),
        .adv  (adv),
        .mag  (magu_reg),
        .inv  (inv_reg),
        .imp  (side_reg[1].imp),
        .g    (gu)
    );

    bgre_lane #(.ADDR_BITS(EXP_TABLE_ADDR_BITS)) u_lane_x (
        .aclk (aclk),
        .adv  (adv),
        .mag  (magx_reg),
        .inv  (inv_reg),
        .imp  (1'b0),
        .g    (gx)
    );

    always_comb begin
        diff = signed'({1'b0, gx}) - signed'({1'b0, gu});
        rnd  = prod_reg + 61'sd32768;
        sum  = 46'(signed'(rnd[60:16])) + 46'(base_reg);
        resp_next = '0;
        sat_next  = 1'b0;
        if (side_reg[NStg-1].imp) begin
            resp_next = side_reg[NStg-1].pos ? {4'b0, gu9_reg} : '0;
        end else if (!side_reg[NStg-1].pos) begin
            resp_next = base_reg;
        end else if (sum > 46'sh0_7FFF_FFFF) begin
            resp_next = 32'h7FFF_FFFF;
            sat_next  = 1'b1;
        end else if (sum < -46'sh0_8000_0000) begin
            resp_next = 32'h8000_0000;
            sat_next  = 1'b1;
        end else begin
            resp_next = sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg  <= resp_next;
            m_sat_reg   <= sat_next;
            m_last_reg  <= side_reg[NStg-1].last;
            out_imp_reg <= side_reg[NStg-1].imp;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_sat_reg;
    assign m_tlast    = m_last_reg;

    `BGRE_ASSERT_IMPL(a_sat_at_rail, m_tvalid && m_tuser[0], (m_tdata == 32'h7FFF_FFFF) || (m_tdata == 32'h8000_0000))
    `BGRE_ASSERT_IMPL(a_impulse_small, m_tvalid && out_imp_reg, !m_tdata[31] && !m_tuser[0])
    `BGRE_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, $stable(vld_reg) && m_tvalid)

endmodule
`default_nettype wire
